// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rrv_pkg.sv =====
// Shared constants, datapath operation codes and control structs.
package rrv_pkg;

  localparam int PRICE_W    = 32;
  localparam int RET_W      = 32;
  localparam int FRAC_W     = 28;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 62;
  localparam int VOL_W      = 28;
  localparam int WIN_W      = 9;
  localparam int MAX_WIN    = 256;
  localparam int POS_W      = 8;
  localparam int ACC_W      = 64;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 6;
  localparam int WIN_RESET  = 20;
  localparam int SQ_SHIFT   = 2 * FRAC_W - 48;
  localparam int TDATA_W    = 32;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SET_PREV,
    OP_ZERO_RET,
    OP_RET_LOAD,
    OP_DIV_STEP,
    OP_RET_TAKE,
    OP_SQ_OLD,
    OP_SQ_NEW,
    OP_SQ_SUB,
    OP_SQ_ADD,
    OP_MEAN_LOAD,
    OP_MEAN_TAKE,
    OP_M2_LOAD,
    OP_VAR_TAKE,
    OP_SQRT_STEP,
    OP_VOL_TAKE,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic have_prev;
    logic prev_zero;
    logic held_gt1;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/rrv_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rrv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rrv_dp.sv =====
// Datapath: shared divider, squarer, running sums, ring, square root, output register.
module rrv_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrv_pkg::cmd_t                   cmd,
  output rrv_pkg::stat_t                  stat,
  input  logic [rrv_pkg::PRICE_W-1:0]     in_tdata,
  input  logic                            in_tuser,
  input  logic                            cfg_wr_en,
  input  logic [rrv_pkg::WIN_W-1:0]       cfg_wr_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rrv_pkg::TDATA_W-1:0]     out_tdata
);

  localparam int PW = rrv_pkg::PRICE_W;
  localparam int RW = rrv_pkg::RET_W;
  localparam int AW = rrv_pkg::ACC_W;

  logic [PW-1:0]                price_r, prev_r;
  logic                         pvalid_r, have_prev_r, zflag_r;
  logic signed [RW-1:0]         ret_r, old_r;
  logic                         neg_r, sat_r;
  logic [AW-1:0]                dvd_r;
  logic [31:0]                  rem_r, dvs_r;
  logic [31:0]                  mul_a_r;
  logic [AW-1:0]                prod_r;
  logic signed [rrv_pkg::SUM_W-1:0] sum_r;
  logic [rrv_pkg::SQ_W-1:0]     sq_r;
  logic [rrv_pkg::POS_W-1:0]    pos_r;
  logic [rrv_pkg::WIN_W-1:0]    held_r, wl_r;
  logic [AW-1:0]                sv_r, res_r, bit_r;
  logic [rrv_pkg::VOL_W-1:0]    vol_r;
  logic                         out_valid_r;
  logic [rrv_pkg::TDATA_W-1:0]  out_data_r;

  logic [RW-1:0]                rd_data;
  logic [PW-1:0]                diff;
  logic [32:0]                  div_t, div_sub;
  logic                         div_ge;
  logic [RW-1:0]                old_val, old_mag, ret_mag, ret_q;
  logic [rrv_pkg::SUM_W-1:0]    sum_mag;
  logic [AW-1:0]                msq, sqrt_try;
  logic                         sqrt_ge;
  logic [rrv_pkg::WIN_W-1:0]    pos_inc, cfg_sat;

  rrv_ram #(.WIDTH(RW), .DEPTH(rrv_pkg::MAX_WIN)) u_ring (
    .clk     (clk),
    .wr_en   (cmd.op == rrv_pkg::OP_SQ_SUB),
    .wr_addr (pos_r),
    .wr_data (ret_r),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    diff     = (price_r >= prev_r) ? price_r - prev_r : prev_r - price_r;
    div_t    = {rem_r, dvd_r[AW-1]};
    div_sub  = div_t - {1'b0, dvs_r};
    div_ge   = div_t >= {1'b0, dvs_r};
    old_val  = (held_r == wl_r) ? rd_data : '0;
    old_mag  = old_val[RW-1] ? ~old_val + 32'd1 : old_val;
    ret_mag  = ret_r[RW-1] ? ~ret_r + 32'd1 : ret_r;
    ret_q    = {1'b0, dvd_r[RW-2:0]};
    sum_mag  = sum_r[rrv_pkg::SUM_W-1] ? ~sum_r + 40'd1 : sum_r;
    msq      = prod_r >> rrv_pkg::SQ_SHIFT;
    sqrt_try = res_r + bit_r;
    sqrt_ge  = sv_r >= sqrt_try;
    pos_inc  = {1'b0, pos_r} + 9'd1;
    cfg_sat  = (cfg_wr_data > 9'(rrv_pkg::MAX_WIN)) ? 9'(rrv_pkg::MAX_WIN) : cfg_wr_data;
  end

  // squarer, registered; operand held until changed
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      wl_r        <= 9'(rrv_pkg::WIN_RESET);
      vol_r       <= '0;
      out_valid_r <= 1'b0;
      pvalid_r    <= 1'b0;
      zflag_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_sat != '0) begin
          wl_r <= cfg_sat;
        end
        pos_r  <= '0;
        held_r <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
      end
      if (cmd.op == rrv_pkg::OP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        rrv_pkg::OP_CAPTURE: begin
          price_r  <= in_tdata;
          pvalid_r <= in_tuser;
          zflag_r  <= 1'b0;
        end
        rrv_pkg::OP_SET_PREV: begin
          have_prev_r <= 1'b1;
          prev_r      <= price_r;
        end
        rrv_pkg::OP_ZERO_RET: begin
          ret_r   <= '0;
          zflag_r <= 1'b1;
        end
        rrv_pkg::OP_RET_LOAD: begin
          dvd_r <= {4'b0, diff, 28'b0};
          rem_r <= '0;
          dvs_r <= prev_r;
          neg_r <= price_r < prev_r;
          sat_r <= {3'b0, diff} >= {prev_r, 3'b0};
        end
        rrv_pkg::OP_DIV_STEP: begin
          rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
          dvd_r <= {dvd_r[AW-2:0], div_ge};
        end
        rrv_pkg::OP_RET_TAKE: begin
          if (sat_r) begin
            ret_r <= neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            ret_r <= neg_r ? ~ret_q + 32'd1 : ret_q;
          end
        end
        rrv_pkg::OP_SQ_OLD: begin
          old_r   <= old_val;
          mul_a_r <= old_mag;
        end
        rrv_pkg::OP_SQ_NEW: begin
          mul_a_r <= ret_mag;
        end
        rrv_pkg::OP_SQ_SUB: begin
          sq_r  <= sq_r - rrv_pkg::SQ_W'(msq);
          sum_r <= sum_r + rrv_pkg::SUM_W'(ret_r) - rrv_pkg::SUM_W'(old_r);
        end
        rrv_pkg::OP_SQ_ADD: begin
          sq_r   <= sq_r + rrv_pkg::SQ_W'(msq);
          pos_r  <= (pos_inc == wl_r) ? '0 : pos_inc[rrv_pkg::POS_W-1:0];
          held_r <= (held_r < wl_r) ? held_r + 9'd1 : held_r;
          prev_r <= price_r;
        end
        rrv_pkg::OP_MEAN_LOAD: begin
          dvd_r <= {24'b0, sum_mag};
          rem_r <= '0;
          dvs_r <= {23'b0, held_r};
        end
        rrv_pkg::OP_MEAN_TAKE: begin
          mul_a_r <= dvd_r[31:0];
        end
        rrv_pkg::OP_M2_LOAD: begin
          dvd_r <= {2'b0, sq_r};
          rem_r <= '0;
          dvs_r <= {23'b0, held_r};
        end
        rrv_pkg::OP_VAR_TAKE: begin
          sv_r  <= (dvd_r > msq) ? dvd_r - msq : '0;
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
        rrv_pkg::OP_SQRT_STEP: begin
          if (sqrt_ge) begin
            sv_r  <= sv_r - sqrt_try;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        rrv_pkg::OP_VOL_TAKE: begin
          vol_r <= (res_r > 64'hFFF_FFFF) ? 28'hFFF_FFFF : res_r[rrv_pkg::VOL_W-1:0];
        end
        rrv_pkg::OP_OUT_LOAD: begin
          out_data_r <= {2'b0, zflag_r, held_r > 9'd1, vol_r};
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.valid     = pvalid_r;
  assign stat.have_prev = have_prev_r;
  assign stat.prev_zero = prev_r == '0;
  assign stat.held_gt1  = held_r > 9'd1;
  assign stat.out_free  = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;

endmodule

// ===== hdl/rrv_ctrl.sv =====
// Sequencer that steps the datapath through one price request.
module rrv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rrv_pkg::stat_t stat,
  output rrv_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RDIV, S_RTAKE, S_RD_OLD, S_SQ_OLD, S_SQ_NEW, S_SQ_SUB,
    S_SQ_ADD, S_STATS, S_MDIV, S_MTAKE, S_M2LOAD, S_M2DIV, S_VTAKE, S_SQRT,
    S_VOL, S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [rrv_pkg::CNT_W-1:0] cnt_r;
  logic                      div_last, sqrt_last;

  assign div_last  = cnt_r == 6'(rrv_pkg::DIV_STEPS - 1);
  assign sqrt_last = cnt_r == 6'(rrv_pkg::SQRT_STEPS - 1);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rrv_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = rrv_pkg::OP_CAPTURE;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat.valid) begin
          state_nxt = S_DONE;
        end else if (!stat.have_prev) begin
          cmd.op    = rrv_pkg::OP_SET_PREV;
          state_nxt = S_STATS;
        end else if (stat.prev_zero) begin
          cmd.op    = rrv_pkg::OP_ZERO_RET;
          state_nxt = S_RD_OLD;
        end else begin
          cmd.op    = rrv_pkg::OP_RET_LOAD;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.op = rrv_pkg::OP_DIV_STEP;
        if (div_last) state_nxt = S_RTAKE;
      end
      S_RTAKE: begin
        cmd.op    = rrv_pkg::OP_RET_TAKE;
        state_nxt = S_RD_OLD;
      end
      S_RD_OLD: state_nxt = S_SQ_OLD;
      S_SQ_OLD: begin
        cmd.op    = rrv_pkg::OP_SQ_OLD;
        state_nxt = S_SQ_NEW;
      end
      S_SQ_NEW: begin
        cmd.op    = rrv_pkg::OP_SQ_NEW;
        state_nxt = S_SQ_SUB;
      end
      S_SQ_SUB: begin
        cmd.op    = rrv_pkg::OP_SQ_SUB;
        state_nxt = S_SQ_ADD;
      end
      S_SQ_ADD: begin
        cmd.op    = rrv_pkg::OP_SQ_ADD;
        state_nxt = S_STATS;
      end
      S_STATS: begin
        if (stat.held_gt1) begin
          cmd.op    = rrv_pkg::OP_MEAN_LOAD;
          state_nxt = S_MDIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MDIV: begin
        cmd.op = rrv_pkg::OP_DIV_STEP;
        if (div_last) state_nxt = S_MTAKE;
      end
      S_MTAKE: begin
        cmd.op    = rrv_pkg::OP_MEAN_TAKE;
        state_nxt = S_M2LOAD;
      end
      S_M2LOAD: begin
        cmd.op    = rrv_pkg::OP_M2_LOAD;
        state_nxt = S_M2DIV;
      end
      S_M2DIV: begin
        cmd.op = rrv_pkg::OP_DIV_STEP;
        if (div_last) state_nxt = S_VTAKE;
      end
      S_VTAKE: begin
        cmd.op    = rrv_pkg::OP_VAR_TAKE;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = rrv_pkg::OP_SQRT_STEP;
        if (sqrt_last) state_nxt = S_VOL;
      end
      S_VOL: begin
        cmd.op    = rrv_pkg::OP_VOL_TAKE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = rrv_pkg::OP_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RDIV || state_r == S_MDIV || state_r == S_M2DIV ||
          state_r == S_SQRT) begin
        cnt_r <= cnt_r + 6'd1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  assign in_tready = state_r == S_IDLE;

endmodule

// ===== hdl/rolling_return_volatility.sv =====
// Top level of the rolling return volatility block.
// Input stream: in_tdata carries one price, in_tuser flags that it is valid.
// Each request yields exactly one result on the output stream: volatility
// (Q4.24 standard deviation of the windowed returns), a ready flag once more
// than one return is held, and a flag for a return taken on a zero price.
// cfg_wr_en/cfg_wr_data set the window length (0 keeps it, above 256
// saturates) and clear the window; write only while the block is idle.
// Latency from the accepting edge to out_tvalid depends on the path: a full
// update runs three 64-step divisions on one shared restoring divider plus a
// 32-step square root; a zero previous price skips the return division,
// fewer than two held returns skip the mean, variance and square root, and a
// first or an invalid price goes straight to the result.
// One request is worked at a time; the next is taken once the result sits
// in the output register, even if the receiver has not taken it yet.
// A stalled receiver keeps the next result waiting in the datapath until the
// output register frees. Reset: window length 20, empty window, volatility 0.
`include "assert_macros.svh"

module rolling_return_volatility (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] price
  input  logic        in_tuser,    // [0] price_valid
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // [27:0] volatility, [28] volatility_ready,
                                   // [29] zero_price_seen
);

  rrv_pkg::cmd_t  cmd;
  rrv_pkg::stat_t stat;

  rrv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrv_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  `ASSERT_IMPL(a_capture_on_accept, cmd.op == rrv_pkg::OP_CAPTURE, in_tvalid && in_tready, "capture without request")
  `ASSERT_IMPL(a_load_when_free, cmd.op == rrv_pkg::OP_OUT_LOAD, stat.out_free, "output overwritten")
  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")

endmodule
